// ===== src/ndtp_pkg.sv =====
// ----------------------------------------------------------------------------
// ndtp_pkg
// Shared constants, register codes and reset values of the downscale,
// threshold and pack block.
// ----------------------------------------------------------------------------
package ndtp_pkg;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int CFG_SW_W   = 13;
    localparam int CFG_SH_W   = 13;
    localparam int CFG_DOTS_W = 12;
    localparam int CFG_DARK_W = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // default sizing
    localparam int DEF_MAX_SIDE       = 4096;
    localparam int DEF_MAX_PRINT_DOTS = 2048;

    // register reset values
    localparam int RST_SOURCE_WIDTH  = 384;
    localparam int RST_SOURCE_HEIGHT = 1;
    localparam int RST_PRINT_DOTS    = 384;
    localparam int RST_DARK_LEVEL    = 128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_PRINT_DOTS    = 2'd2,
        REG_DARK_LEVEL    = 2'd3
    } t_reg_idx;

endpackage

// ===== src/ndtp_pix_if.sv =====
// ----------------------------------------------------------------------------
// ndtp_pix_if
// Valid/ready channel carrying one grayscale source pixel per transfer.
// ----------------------------------------------------------------------------
interface ndtp_pix_if;
    import ndtp_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== src/ndtp_pack_if.sv =====
// ----------------------------------------------------------------------------
// ndtp_pack_if
// Valid/ready channel carrying one packed byte of printer dots per transfer.
// ----------------------------------------------------------------------------
interface ndtp_pack_if;
    import ndtp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packed_bits;
    logic              row_end;
    logic              image_end;

    modport source (output valid, output packed_bits, output row_end, output image_end,
                    input ready);
    modport sink   (input valid, input packed_bits, input row_end, input image_end,
                    output ready);
endinterface

// ===== src/ndtp_cfg.sv =====
// ----------------------------------------------------------------------------
// ndtp_cfg
// Configuration registers plus registered clamped geometry: source width,
// source height, output width and the row limit product.
// ----------------------------------------------------------------------------
module ndtp_cfg #(
    parameter int  MAX_SIDE       = ndtp_pkg::DEF_MAX_SIDE,
    parameter int  MAX_PRINT_DOTS = ndtp_pkg::DEF_MAX_PRINT_DOTS,
    localparam int W_SIDE         = $clog2(MAX_SIDE + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  ndtp_pkg::t_reg_idx              i_cfg_idx,
    input  logic [ndtp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic [W_SIDE-1:0]               o_sw,
    output logic [W_SIDE-1:0]               o_sh,
    output logic [W_SIDE-1:0]               o_dw,
    output logic [2*W_SIDE-1:0]             o_lim,
    output logic [ndtp_pkg::PIX_W-1:0]      o_dark,
    output logic                            o_sw_wr,
    output logic [W_SIDE-1:0]               o_sw_new
);
    import ndtp_pkg::*;

    localparam int W_DOTS = $clog2(MAX_PRINT_DOTS + 1);
    localparam int W_CS   = (CFG_SW_W > W_SIDE) ? CFG_SW_W : W_SIDE;
    localparam int W_CD0  = (CFG_DOTS_W > W_DOTS) ? CFG_DOTS_W : W_DOTS;
    localparam int W_CD   = (W_CD0 > W_SIDE) ? W_CD0 : W_SIDE;

    logic [CFG_SW_W-1:0]   r_source_width;
    logic [CFG_SH_W-1:0]   r_source_height;
    logic [CFG_DOTS_W-1:0] r_print_dots;
    logic [CFG_DARK_W-1:0] r_dark_level;

    logic [W_SIDE-1:0]   r_sw, r_sh, r_dw;
    logic [2*W_SIDE-1:0] r_lim;

    logic [W_CS-1:0]     sw_ext, sh_ext, wd_ext;
    logic [W_CD-1:0]     dots_ext, dots_cl;
    logic [W_SIDE-1:0]   sw_cl, sh_cl, wd_cl, dw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= CFG_SW_W'(RST_SOURCE_WIDTH);
            r_source_height <= CFG_SH_W'(RST_SOURCE_HEIGHT);
            r_print_dots    <= CFG_DOTS_W'(RST_PRINT_DOTS);
            r_dark_level    <= CFG_DARK_W'(RST_DARK_LEVEL);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SOURCE_WIDTH:  r_source_width  <= i_cfg_wdata[CFG_SW_W-1:0];
                REG_SOURCE_HEIGHT: r_source_height <= i_cfg_wdata[CFG_SH_W-1:0];
                REG_PRINT_DOTS:    r_print_dots    <= i_cfg_wdata[CFG_DOTS_W-1:0];
                REG_DARK_LEVEL:    r_dark_level    <= i_cfg_wdata[CFG_DARK_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to the legal ranges, output width is the smaller of the two
    always_comb begin
        sw_ext   = W_CS'(r_source_width);
        sh_ext   = W_CS'(r_source_height);
        wd_ext   = W_CS'(i_cfg_wdata[CFG_SW_W-1:0]);
        dots_ext = W_CD'(r_print_dots);

        if (sw_ext == '0)                 sw_cl = W_SIDE'(1);
        else if (sw_ext > W_CS'(MAX_SIDE)) sw_cl = W_SIDE'(MAX_SIDE);
        else                              sw_cl = W_SIDE'(sw_ext);

        if (sh_ext == '0)                 sh_cl = W_SIDE'(1);
        else if (sh_ext > W_CS'(MAX_SIDE)) sh_cl = W_SIDE'(MAX_SIDE);
        else                              sh_cl = W_SIDE'(sh_ext);

        if (wd_ext == '0)                 wd_cl = W_SIDE'(1);
        else if (wd_ext > W_CS'(MAX_SIDE)) wd_cl = W_SIDE'(MAX_SIDE);
        else                              wd_cl = W_SIDE'(wd_ext);

        if (dots_ext == '0)                         dots_cl = W_CD'(1);
        else if (dots_ext > W_CD'(MAX_PRINT_DOTS))  dots_cl = W_CD'(MAX_PRINT_DOTS);
        else                                        dots_cl = dots_ext;

        dw = (dots_cl < W_CD'(sw_cl)) ? W_SIDE'(dots_cl) : sw_cl;
    end

    always_ff @(posedge i_clk) begin
        r_sw  <= sw_cl;
        r_sh  <= sh_cl;
        r_dw  <= dw;
        r_lim <= (2*W_SIDE)'(sh_cl) * (2*W_SIDE)'(dw);
    end

    assign o_sw     = r_sw;
    assign o_sh     = r_sh;
    assign o_dw     = r_dw;
    assign o_lim    = r_lim;
    assign o_dark   = r_dark_level;
    assign o_sw_wr  = i_cfg_we && (i_cfg_idx == REG_SOURCE_WIDTH);
    assign o_sw_new = wd_cl;

endmodule

// ===== src/ndtp_core.sv =====
// ----------------------------------------------------------------------------
// ndtp_core
// Input register, row/column pick with error accumulators, dot packing and
// output register.
// ----------------------------------------------------------------------------
module ndtp_core #(
    parameter int  MAX_SIDE       = ndtp_pkg::DEF_MAX_SIDE,
    parameter int  MAX_PRINT_DOTS = ndtp_pkg::DEF_MAX_PRINT_DOTS,
    localparam int W_SIDE         = $clog2(MAX_SIDE + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ndtp_pix_if.sink                   i_pix,
    ndtp_pack_if.source                o_pack,
    input  logic [W_SIDE-1:0]          i_sw,
    input  logic [W_SIDE-1:0]          i_sh,
    input  logic [W_SIDE-1:0]          i_dw,
    input  logic [2*W_SIDE-1:0]        i_lim,
    input  logic [ndtp_pkg::PIX_W-1:0] i_dark,
    input  logic                       i_sw_wr,
    input  logic [W_SIDE-1:0]          i_sw_new
);
    import ndtp_pkg::*;

    localparam int W_COL  = $clog2(MAX_SIDE);
    localparam int W_OCOL = $clog2(MAX_PRINT_DOTS + 1);
    localparam int W_CM   = (W_OCOL > W_SIDE) ? W_OCOL : W_SIDE;
    localparam int W_PROD = 2*W_SIDE + 1;
    localparam int W_BC   = $clog2(BYTE_W);
    localparam int RST_ACC = (RST_SOURCE_WIDTH > MAX_SIDE) ? MAX_SIDE : RST_SOURCE_WIDTH;

    function automatic logic [W_SIDE-1:0] f_next_err(input logic [W_SIDE-1:0] e,
                                                      input logic [W_SIDE-1:0] sw,
                                                      input logic [W_SIDE-1:0] dw);
        logic [W_SIDE:0] s;
        s = {1'b0, e} + {1'b0, sw} - {1'b0, dw};
        return (e < dw) ? s[W_SIDE-1:0] : (e - dw);
    endfunction

    // handshake and payload registers
    logic              r_up;
    logic              r_in_valid;
    logic [PIX_W-1:0]  r_pixel;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_bits;
    logic              r_out_row_end;
    logic              r_out_image_end;

    // position state
    logic [W_COL-1:0]  r_src_column, n_src_column;
    logic [W_COL-1:0]  r_src_row, n_src_row;
    logic [W_SIDE-1:0] r_col_error, n_col_error;
    logic [W_SIDE-1:0] r_row_error, n_row_error;
    logic [W_OCOL-1:0] r_out_column, n_out_column;
    logic [W_SIDE-1:0] r_out_row, n_out_row;
    logic [W_PROD-1:0] r_acc1, n_acc1;      // (out_row + 1) * source width
    logic              r_row_picked, n_row_picked;
    logic [BYTE_W-1:0] r_bit_shifter, n_bit_shifter;
    logic [W_BC-1:0]   r_bit_count, n_bit_count;

    logic              adv, in_take;
    logic              col0, row_ok, picked_now, pick, dot, last, emit, img_end;
    logic              row_done, img_done;
    logic [BYTE_W-1:0] sh_nx, out_bits;
    logic [W_OCOL-1:0] oc_inc;
    logic [W_PROD:0]   acc_sum;
    logic [W_PROD-1:0] acc_wr;

    assign adv         = r_in_valid && (!r_out_valid || o_pack.ready);
    assign i_pix.ready = r_up && (!r_in_valid || adv);
    assign in_take     = i_pix.valid && i_pix.ready;

    assign acc_wr = W_PROD'({1'b0, r_out_row} + (W_SIDE+1)'(1)) * W_PROD'(i_sw_new);

    always_comb begin
        col0       = (r_src_column == '0);
        row_ok     = (r_row_error < i_dw) && (r_acc1 <= W_PROD'(i_lim));
        picked_now = col0 ? row_ok : r_row_picked;
        pick       = picked_now && (r_col_error < i_dw) && (W_CM'(r_out_column) < W_CM'(i_dw));
        dot        = (r_pixel < i_dark);
        sh_nx      = {r_bit_shifter[BYTE_W-2:0], dot};
        oc_inc     = r_out_column + W_OCOL'(1);
        last       = (W_CM'(oc_inc) == W_CM'(i_dw));
        emit       = pick && ((r_bit_count == W_BC'(BYTE_W-1)) || last);
        out_bits   = sh_nx << (W_BC'(BYTE_W-1) - r_bit_count);
        acc_sum    = {1'b0, r_acc1} + (W_PROD+1)'(i_sw);
        img_end    = last && (r_acc1 <= W_PROD'(i_lim))
                     && (acc_sum > (W_PROD+1)'(i_lim));
        row_done   = ({1'b0, W_SIDE'(r_src_column)} + (W_SIDE+1)'(1)) >= {1'b0, i_sw};
        img_done   = ({1'b0, W_SIDE'(r_src_row)} + (W_SIDE+1)'(1)) >= {1'b0, i_sh};

        n_src_column  = r_src_column;
        n_src_row     = r_src_row;
        n_col_error   = r_col_error;
        n_row_error   = r_row_error;
        n_out_column  = r_out_column;
        n_out_row     = r_out_row;
        n_acc1        = r_acc1;
        n_row_picked  = r_row_picked;
        n_bit_shifter = r_bit_shifter;
        n_bit_count   = r_bit_count;

        if (adv) begin
            n_row_picked = picked_now;
            n_col_error  = f_next_err(r_col_error, i_sw, i_dw);
            if (pick) begin
                n_out_column = oc_inc;
                if (emit) begin
                    n_bit_shifter = '0;
                    n_bit_count   = '0;
                end else begin
                    n_bit_shifter = sh_nx;
                    n_bit_count   = r_bit_count + W_BC'(1);
                end
            end
            if (row_done) begin
                n_src_column  = '0;
                n_col_error   = '0;
                n_out_column  = '0;
                n_bit_shifter = '0;
                n_bit_count   = '0;
                if (picked_now) begin
                    n_out_row = r_out_row + W_SIDE'(1);
                    n_acc1    = acc_sum[W_PROD-1:0];
                end
                n_row_error = f_next_err(r_row_error, i_sw, i_dw);
                if (img_done) begin
                    n_src_row   = '0;
                    n_row_error = '0;
                    n_out_row   = '0;
                    n_acc1      = W_PROD'(i_sw);
                end else begin
                    n_src_row = r_src_row + W_COL'(1);
                end
            end else begin
                n_src_column = r_src_column + W_COL'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up          <= 1'b0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_src_column  <= '0;
            r_src_row     <= '0;
            r_col_error   <= '0;
            r_row_error   <= '0;
            r_out_column  <= '0;
            r_out_row     <= '0;
            r_acc1        <= W_PROD'(RST_ACC);
            r_row_picked  <= 1'b1;
            r_bit_shifter <= '0;
            r_bit_count   <= '0;
        end else begin
            r_up       <= 1'b1;
            r_in_valid <= in_take || (r_in_valid && !adv);
            if (adv && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pack.ready) begin
                r_out_valid <= 1'b0;
            end
            r_src_column  <= n_src_column;
            r_src_row     <= n_src_row;
            r_col_error   <= n_col_error;
            r_row_error   <= n_row_error;
            r_out_column  <= n_out_column;
            r_out_row     <= n_out_row;
            r_row_picked  <= n_row_picked;
            r_bit_shifter <= n_bit_shifter;
            r_bit_count   <= n_bit_count;
            // new source width rescales the row product
            if (i_sw_wr) begin
                r_acc1 <= acc_wr;
            end else begin
                r_acc1 <= n_acc1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pixel <= i_pix.pixel;
        end
        if (adv && emit) begin
            r_out_bits      <= out_bits;
            r_out_row_end   <= last;
            r_out_image_end <= img_end;
        end
    end

    assign o_pack.valid       = r_out_valid;
    assign o_pack.packed_bits = r_out_bits;
    assign o_pack.row_end     = r_out_row_end;
    assign o_pack.image_end   = r_out_image_end;

    a_output_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_pack.ready |=> r_out_valid && $stable(r_out_bits))
        else $error("stalled output byte lost or overwritten");

    a_image_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_image_end |-> r_out_row_end)
        else $error("image end without row end");

    a_row_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && row_done |=> (r_src_column == '0) && (r_out_column == '0)
                            && (r_bit_count == '0))
        else $error("row state not cleared at end of source row");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_pixel))
        else $error("held pixel lost or overwritten");

endmodule

// ===== src/nn_downscale_threshold_pack_top.sv =====
// ----------------------------------------------------------------------------
// nn_downscale_threshold_pack_top
// Nearest-neighbor downscale of an 8-bit grayscale raster to a 1-bit,
// byte-packed thermal printer raster.
// ----------------------------------------------------------------------------
// Source pixels stream in raster order, one per transfer, and the block
// emits the printer raster as bytes of eight dots, leftmost dot in bit 7,
// 1 for black. Output width is min(source width, print dots), output height
// is floor(source height * output width / source width); row and column
// picks come from integer error accumulators, so the scale is exact. A
// picked pixel strictly below dark_level prints black. The last byte of each
// output row is zero padded and flagged with row_end, the last byte of the
// image also carries image_end. Pixels that are not picked are consumed with
// no output. After the last pixel of the last source row the position state
// wraps and the next pixel starts a new image.
// Throughput is one pixel per clock while o_pack does not stall: every pixel
// passes through one input register, the counter and accumulator logic, and
// one output register; a byte is loaded into the output register when its
// last pixel leaves the input register and is held there until o_pack takes
// it. Backpressure on o_pack stalls the input only when both registers are
// full. No pixel is taken before r_up is set after reset.
// Configuration writes land in the registers and the clamped geometry is
// registered from them, so write only while no pixel is in flight.
// ----------------------------------------------------------------------------
module nn_downscale_threshold_pack_top #(
    parameter int MAX_SIDE       = ndtp_pkg::DEF_MAX_SIDE,
    parameter int MAX_PRINT_DOTS = ndtp_pkg::DEF_MAX_PRINT_DOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  ndtp_pkg::t_reg_idx              i_cfg_idx,
    input  logic [ndtp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // streams
    ndtp_pix_if.sink                        i_pix,
    ndtp_pack_if.source                     o_pack
);
    import ndtp_pkg::*;

    localparam int W_SIDE = $clog2(MAX_SIDE + 1);

    // clamped geometry shared by the pick logic
    logic [W_SIDE-1:0]   sw, sh, dw;
    logic [2*W_SIDE-1:0] lim;          // source height * output width
    logic [PIX_W-1:0]    dark;
    logic                sw_wr;        // source width written this cycle
    logic [W_SIDE-1:0]   sw_new;

    ndtp_cfg #(
        .MAX_SIDE       (MAX_SIDE),
        .MAX_PRINT_DOTS (MAX_PRINT_DOTS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sw        (sw),
        .o_sh        (sh),
        .o_dw        (dw),
        .o_lim       (lim),
        .o_dark      (dark),
        .o_sw_wr     (sw_wr),
        .o_sw_new    (sw_new)
    );

    // pick, threshold and pack, one pixel per clock while o_pack is not stalled
    ndtp_core #(
        .MAX_SIDE       (MAX_SIDE),
        .MAX_PRINT_DOTS (MAX_PRINT_DOTS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .o_pack   (o_pack),
        .i_sw     (sw),
        .i_sh     (sh),
        .i_dw     (dw),
        .i_lim    (lim),
        .i_dark   (dark),
        .i_sw_wr  (sw_wr),
        .i_sw_new (sw_new)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-neighbor downscale, threshold and
// pack block: a short table of directed pixels and register settings, then
// random phases of whole and broken images, every packed byte compared
// with a cycle-free model of the scaler kept in step with the accepted
// pixels.
// ----------------------------------------------------------------------------
module testbench;
    import ndtp_pkg::*;

    localparam int          MAX_SIDE       = DEF_MAX_SIDE;
    localparam int          MAX_PRINT_DOTS = DEF_MAX_PRINT_DOTS;
    localparam int          DIRECTED_STEPS = 30;
    localparam int unsigned RANDOM_PIXELS  = 750;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned PRESSURE_PHASE = 2;

    // one packed byte of printer dots
    typedef struct packed {
        logic [BYTE_W-1:0] bits;
        logic              row_end;
        logic              image_end;
    } dot_byte_t;

    // one row of the directed table: either a full register setting or a pixel,
    // with the expected byte written in only where it is obvious
    typedef struct packed {
        logic              cfg;
        logic [12:0]       sw;
        logic [12:0]       sh;
        logic [12:0]       dots;
        logic [12:0]       dark;
        logic [PIX_W-1:0]  pixel;
        logic              typed;
        logic              has_byte;
        logic [BYTE_W-1:0] typed_bits;
        logic              typed_row_end;
        logic              typed_image_end;
    } step_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_reg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ndtp_pix_if  pix_if ();
    ndtp_pack_if pack_if ();

    nn_downscale_threshold_pack_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_pix       (pix_if),
        .o_pack      (pack_if)
    );

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------
    step_t directed_steps [DIRECTED_STEPS] = '{
        //  cfg sw    sh    dots  dark  pixel typed has bits   re ie
        // zero registers clamp to one: every pixel is a whole image of one dot
        '{1,  0,    0,    0,    255,  0,    0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    0,    1,    1,  8'h80, 1, 1},
        '{0,  0,    0,    0,    0,    254,  1,    1,  8'h80, 1, 1},
        '{0,  0,    0,    0,    0,    255,  1,    1,  8'h00, 1, 1},
        // dark level zero: nothing prints black
        '{1,  0,    0,    0,    0,    0,    0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    0,    1,    1,  8'h00, 1, 1},
        // output height rounds down to zero: empty image, no bytes
        '{1,  2,    1,    1,    128,  0,    0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    0,    1,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    0,    1,    0,  8'h00, 0, 0},
        // registers above range clamp to the largest geometry, every other pixel
        '{1,  8191, 8191, 4095, 128,  0,    0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    0,    0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    255,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    127,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    255,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    128,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    0,    0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    127,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    255,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    255,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    0,    0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    0,    0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    255,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    128,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    127,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    255,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    0,    0,    0,  8'h00, 0, 0},
        // new geometry in the middle of an image, narrow row with padding
        '{1,  12,   3,    5,    200,  0,    0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    199,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    200,  0,    0,  8'h00, 0, 0},
        '{0,  0,    0,    0,    0,    0,    0,    0,  8'h00, 0, 0}
    };

    // ------------------------------------------------------------------------
    // scaler model: register copy and position state
    // ------------------------------------------------------------------------
    logic [12:0] cfg_sw   = 13'(RST_SOURCE_WIDTH);
    logic [12:0] cfg_sh   = 13'(RST_SOURCE_HEIGHT);
    logic [11:0] cfg_dots = 12'(RST_PRINT_DOTS);
    logic [7:0]  cfg_dark = 8'(RST_DARK_LEVEL);

    int unsigned src_col    = 0;
    int unsigned src_row    = 0;
    int unsigned col_err    = 0;
    int unsigned row_err    = 0;
    int unsigned out_col    = 0;
    int unsigned out_row    = 0;
    logic        row_picked = 1'b1;
    logic [7:0]  shifter    = '0;
    int unsigned nbits      = 0;

    dot_byte_t   dot_bytes_q [$];
    int unsigned mismatches      = 0;
    int unsigned burst_left      = 0;
    bit          hold_request    = 1'b0;

    function automatic int unsigned clamp_side(input int unsigned v, input int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // error accumulator step: wraps by the source width once it drops below dw
    function automatic int unsigned advance_error(input int unsigned err,
                                                  input int unsigned sw,
                                                  input int unsigned dw);
        return (err < dw) ? err + sw - dw : err - dw;
    endfunction

    // clamped geometry of the current register values
    function automatic void geometry(output int unsigned sw, output int unsigned sh,
                                     output int unsigned dw, output int unsigned dh);
        int unsigned dots;
        sw   = clamp_side(32'(cfg_sw), MAX_SIDE);
        sh   = clamp_side(32'(cfg_sh), MAX_SIDE);
        dots = clamp_side(32'(cfg_dots), MAX_PRINT_DOTS);
        dw   = (dots < sw) ? dots : sw;
        dh   = (sh * dw) / sw;
    endfunction

    // advance the model by one source pixel, returns 1 when a byte comes out
    function automatic bit scale_pixel(input logic [PIX_W-1:0] pixel, output dot_byte_t res);
        int unsigned sw, sh, dw, dh;
        bit pick, last, emit;
        emit = 1'b0;
        res  = '0;
        geometry(sw, sh, dw, dh);
        if (src_col == 0)
            row_picked = (row_err < dw) && (out_row < dh);
        pick    = row_picked && (col_err < dw) && (out_col < dw);
        col_err = advance_error(col_err, sw, dw);
        if (pick) begin
            shifter = {shifter[6:0], pixel < cfg_dark};
            nbits   = nbits + 1;
            out_col = out_col + 1;
            last    = (out_col == dw);
            if (nbits == 8 || last) begin
                res.bits      = shifter << (8 - nbits);
                res.row_end   = last;
                res.image_end = last && (out_row + 1 == dh);
                emit    = 1'b1;
                shifter = '0;
                nbits   = 0;
            end
        end
        if (src_col + 1 >= sw) begin
            // end of source row, a partial byte still held is dropped
            src_col = 0;
            col_err = 0;
            out_col = 0;
            shifter = '0;
            nbits   = 0;
            if (row_picked)
                out_row = out_row + 1;
            row_err = advance_error(row_err, sw, dw);
            if (src_row + 1 >= sh) begin
                src_row = 0;
                row_err = 0;
                out_row = 0;
            end else begin
                src_row = src_row + 1;
            end
        end else begin
            src_col = src_col + 1;
        end
        return emit;
    endfunction

    // pixels still needed to close the current image under the current geometry
    function automatic int unsigned pixels_to_image_end();
        int unsigned sw, sh, dw, dh, row_rest, rows_rest;
        geometry(sw, sh, dw, dh);
        row_rest  = (src_col + 1 >= sw) ? 1 : sw - src_col;
        rows_rest = (src_row + 1 >= sh) ? 0 : sh - src_row - 1;
        return row_rest + rows_rest * sw;
    endfunction

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        // the register keeps only its own width
        case (idx)
            REG_SOURCE_WIDTH:  cfg_sw   = data[12:0];
            REG_SOURCE_HEIGHT: cfg_sh   = data[12:0];
            REG_PRINT_DOTS:    cfg_dots = data[11:0];
            REG_DARK_LEVEL:    cfg_dark = data[7:0];
            default: ;
        endcase
    endtask

    // all four registers back to back, then let the clamped geometry settle
    task automatic program_geometry(input logic [12:0] sw, input logic [12:0] sh,
                                    input logic [12:0] dots, input logic [12:0] dark);
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_PRINT_DOTS, dots);
        write_reg(REG_DARK_LEVEL, dark);
        cfg_we <= 1'b0;
        repeat (3) @(posedge i_clk);
    endtask

    // offer one pixel in bursts with random gaps, queue what it produces
    task automatic push_pixel(input logic [PIX_W-1:0] value, input bit typed,
                              input bit typed_has, input dot_byte_t typed_byte);
        int unsigned gap;
        dot_byte_t   predicted;
        bit          has;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 2);
            if (gap != 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        do @(posedge i_clk); while (pix_if.ready !== 1'b1);
        // transfer done, the model always advances
        has = scale_pixel(value, predicted);
        if (typed) begin
            has       = typed_has;
            predicted = typed_byte;
        end
        if (has)
            dot_bytes_q.push_back(predicted);
    endtask

    // stop offering, wait for every expected byte, then let the block settle
    task automatic drain();
        pix_if.valid <= 1'b0;
        while (dot_bytes_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned random_pixels, phase, n, rem, full, roll;
        int unsigned sw_e, sh_e, dw_e, dh_e;
        logic [12:0] sw_w, sh_w, dots_w, dark_w;
        logic [PIX_W-1:0] value;
        dot_byte_t typed_byte;

        random_pixels = 0;
        phase         = 0;
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= REG_SOURCE_WIDTH;
        cfg_wdata    <= '0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int k = 0; k < DIRECTED_STEPS; k++) begin
            if (directed_steps[k].cfg) begin
                drain();
                program_geometry(directed_steps[k].sw, directed_steps[k].sh,
                                 directed_steps[k].dots, directed_steps[k].dark);
            end else begin
                typed_byte.bits      = directed_steps[k].typed_bits;
                typed_byte.row_end   = directed_steps[k].typed_row_end;
                typed_byte.image_end = directed_steps[k].typed_image_end;
                push_pixel(directed_steps[k].pixel, directed_steps[k].typed,
                           directed_steps[k].has_byte, typed_byte);
            end
        end

        // random phases: new geometry, then mostly whole images
        while (random_pixels < RANDOM_PIXELS) begin
            drain();
            phase++;
            if (phase == PRESSURE_PHASE) begin
                // one dot per image: every pixel is a byte, fills the block fast
                sw_w   = 13'd1;
                sh_w   = 13'd1;
                dots_w = 13'd1;
                dark_w = 13'($urandom_range(1, 254));
            end else begin
                roll = $urandom_range(0, 19);
                case (roll)
                    0:       sw_w = 13'd0;
                    1:       sw_w = 13'($urandom_range(4097, 8191));
                    2:       sw_w = 13'($urandom_range(41, 300));
                    default: sw_w = 13'($urandom_range(1, 40));
                endcase
                roll = $urandom_range(0, 19);
                case (roll)
                    0:       sh_w = 13'd0;
                    1:       sh_w = 13'($urandom_range(4097, 8191));
                    default: sh_w = 13'($urandom_range(1, 10));
                endcase
                roll = $urandom_range(0, 9);
                case (roll)
                    0:       dots_w = 13'd0;
                    1:       dots_w = 13'($urandom_range(2049, 4095));
                    2:       dots_w = 13'($urandom_range(1, 2048));
                    default: dots_w = 13'($urandom_range(1,
                                          clamp_side(32'(sw_w), MAX_SIDE) + 4));
                endcase
                dots_w[12] = 1'($urandom_range(0, 1));   // above the register, dropped
                roll = $urandom_range(0, 9);
                case (roll)
                    0:       dark_w = 13'd0;
                    1:       dark_w = 13'd255;
                    default: dark_w = 13'($urandom_range(0, 255));
                endcase
                dark_w[12:8] = 5'($urandom_range(0, 31));
            end
            program_geometry(sw_w, sh_w, dots_w, dark_w);

            rem = pixels_to_image_end();
            geometry(sw_e, sh_e, dw_e, dh_e);
            full = sw_e * sh_e;
            if (phase == PRESSURE_PHASE) begin
                // long receiver hold-off while pixels keep coming
                hold_request = 1'b1;
                n = $urandom_range(30, 50);
            end else if (rem > 500) begin
                // too big to finish: a piece of it, the next phase picks up mid-image
                n = $urandom_range(20, 120);
            end else begin
                roll = $urandom_range(0, 9);
                if (roll < 8)
                    n = rem + ((full <= 150) ? $urandom_range(0, 2) * full : 0);
                else
                    n = $urandom_range(1, rem);
            end
            // stay within the pixel budget
            if (n > RANDOM_PIXELS - random_pixels)
                n = RANDOM_PIXELS - random_pixels;

            repeat (n) begin
                roll = $urandom_range(0, 7);
                case (roll)
                    0:       value = 8'h00;
                    1:       value = 8'hFF;
                    2:       value = cfg_dark - 8'd1;
                    3:       value = cfg_dark;
                    default: value = 8'($urandom_range(0, 255));
                endcase
                push_pixel(value, 1'b0, 1'b0, '0);
                random_pixels++;
            end
        end

        drain();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: checks each byte transfer, drives ready, watches for a hang
    // ------------------------------------------------------------------------
    initial begin : receiver
        int unsigned idle_cycles, hold_left, mode_left, ready_mode, tick;
        bit          moved;
        dot_byte_t   got, want;

        idle_cycles = 0;
        hold_left   = 0;
        mode_left   = 0;
        ready_mode  = 0;
        tick        = 0;
        pack_if.ready <= 1'b0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            moved = 1'b0;
            if (i_rst_n === 1'b1) begin
                if (pix_if.valid === 1'b1 && pix_if.ready === 1'b1)
                    moved = 1'b1;
                if (pack_if.valid === 1'b1 && pack_if.ready === 1'b1) begin
                    moved         = 1'b1;
                    got.bits      = pack_if.packed_bits;
                    got.row_end   = pack_if.row_end;
                    got.image_end = pack_if.image_end;
                    if (dot_bytes_q.size() == 0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("byte %02h row_end %0b image_end %0b with none expected",
                                     got.bits, got.row_end, got.image_end);
                    end else begin
                        want = dot_bytes_q.pop_front();
                        if (got.bits !== want.bits || got.row_end !== want.row_end ||
                            got.image_end !== want.image_end) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display({"byte mismatch: expected %02h/%0b/%0b, ",
                                          "got %02h/%0b/%0b (bits/row_end/image_end)"},
                                         want.bits, want.row_end, want.image_end,
                                         got.bits, got.row_end, got.image_end);
                        end
                    end
                end
                idle_cycles = moved ? 0 : idle_cycles + 1;
            end

            // stall pattern: modes of random length, overridden by a hold-off
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            if (hold_left != 0) begin
                hold_left--;
                pack_if.ready <= 1'b0;
            end else begin
                case (ready_mode)
                    0:       pack_if.ready <= 1'b1;
                    1:       pack_if.ready <= ($urandom_range(0, 9) < 7);
                    2:       pack_if.ready <= ($urandom_range(0, 9) < 3);
                    default: pack_if.ready <= ((tick % 4) != 0);
                endcase
            end
        end
        // nothing moved for too long
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
